// ----- design/srpc_pkg.sv -----
// ----------------------------------------------------------------------------
// srpc_pkg
// Shared types, constants and the ceiling compare for the SRP ceiling unit.
// ----------------------------------------------------------------------------
package srpc_pkg;

  // Default sizes
  localparam int unsigned NumSems  = 32;
  localparam int unsigned PrioBits = 16;

  // Fixed field widths
  localparam int unsigned OpW   = 3;
  localparam int unsigned SemInW = 5;
  localparam int unsigned PidW  = 22;
  localparam int unsigned PrioW = 16;
  localparam int unsigned PartW = 8;
  localparam int unsigned StatW = 3;

  // Operation codes; codes 6 and 7 are unknown
  typedef enum logic [OpW-1:0] {
    OP_ALLOC  = 3'd0,
    OP_OPEN   = 3'd1,
    OP_CLOSE  = 3'd2,
    OP_LOCK   = 3'd3,
    OP_UNLOCK = 3'd4,
    OP_CHECK  = 3'd5
  } op_e;

  // Status codes
  localparam logic [StatW-1:0] ST_OK     = 3'd0;
  localparam logic [StatW-1:0] ST_PERM   = 3'd1;
  localparam logic [StatW-1:0] ST_BUSY   = 3'd2;
  localparam logic [StatW-1:0] ST_INVAL  = 3'd3;
  localparam logic [StatW-1:0] ST_INLIST = 3'd4;

  // Ceiling key plus owner, as held in one list cell
  typedef struct packed {
    logic [PrioW-1:0] prio;
    logic [PidW-1:0]  pid;
    logic [PidW-1:0]  owner;
  } key_t;

  // Command broadcast to every cell of the ceiling list
  typedef struct packed {
    logic ins;
    logic rem;
    key_t key;
  } chain_cmd_t;

  // One semaphore table entry
  typedef struct packed {
    logic [PrioW-1:0] ceil_prio;
    logic [PidW-1:0]  ceil_pid;
    logic             owner_valid;
    logic [PidW-1:0]  owner_pid;
    logic             bound;
    logic [PartW-1:0] part;
  } tab_ent_t;

  // a beats b: nonzero and either b is zero, smaller, or equal with lower pid
  function automatic logic beats(input logic [PrioW-1:0] ap, input logic [PidW-1:0] apid,
                                 input logic [PrioW-1:0] bp, input logic [PidW-1:0] bpid);
    logic r;
    r = (ap != '0) && ((bp == '0) || (ap < bp) || ((ap == bp) && (apid < bpid)));
    return r;
  endfunction

endpackage

// ----- design/srp_ceiling_unit.sv -----
// ----------------------------------------------------------------------------
// srp_ceiling_unit
// Stack Resource Policy ceiling unit: semaphore table plus sorted ceiling list.
// ----------------------------------------------------------------------------
// Each item takes two steps: the first reads the semaphore's table entry from
// the RAM (registered read), the second decides the status, writes the entry
// back and inserts into or removes from the ceiling list, a row of NUM_SEMS
// cells that shift from the insert or remove point on. The result waits in an
// output register; a new item is accepted while it waits, and the second step
// of the next item holds until the output register is free. The table needs no
// clearing pass after reset: one valid bit per entry makes an unwritten or
// reallocated entry read as all zeros. Results report the list head after the
// operation; top_prio and top_pid are zero when the list is empty.
module srp_ceiling_unit #(
  parameter int unsigned NUM_SEMS  = srpc_pkg::NumSems,
  parameter int unsigned PRIO_BITS = srpc_pkg::PrioBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // op[2:0], sem[7:3], task_pid[29:8], task_prio[45:30], task_partition[53:46],
  // task_is_rt[54], task_holds_global_lock[55]
  input  logic [55:0] s_axis_tdata,
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[2:0], exceeds[3], top_valid[4], top_prio[20:5], top_pid[42:21], zeros above
  output logic [47:0] m_axis_tdata
);

  import srpc_pkg::*;

  localparam int unsigned SemW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam logic [PrioW-1:0] PrioMask =
    (PRIO_BITS >= PrioW) ? {PrioW{1'b1}} : PrioW'((32'd1 << PRIO_BITS) - 32'd1);
  localparam int unsigned EntW = $bits(tab_ent_t);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;

  // latched item
  op_e               op_q;
  logic [SemInW-1:0] sem_q;
  logic [PidW-1:0]   pid_q;
  logic [PrioW-1:0]  prio_q;
  logic [PartW-1:0]  part_q;
  logic              rt_q, glob_q;

  // table
  logic [NUM_SEMS-1:0] tvalid_q;
  logic [SemW-1:0]     sem_addr, raddr;
  logic [EntW-1:0]     rdata_raw;
  tab_ent_t            ent, wdata;
  logic                wr, clr;

  // result register
  logic              out_valid_q;
  logic [StatW-1:0]  status_q, status;
  logic              exceeds_q, exceeds;
  logic              topv_q, head_v;
  logic [PrioW-1:0]  topp_q;
  logic [PidW-1:0]   topid_q;
  key_t              head_key;

  // list chain
  logic        ins, rem;
  chain_cmd_t  cmd;
  logic        valid_sem, accept, fire;
  logic [NUM_SEMS:0] c_valid;
  key_t              c_key [NUM_SEMS+1];
  logic [SemW-1:0]   c_sem [NUM_SEMS+1];
  logic [NUM_SEMS-1:0] c_beaten, c_hit;

  // handshake
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign fire          = (state_q == S_EXEC) && (!out_valid_q || m_axis_tready);

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_EXEC;
      S_EXEC:  if (fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // input capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_e'(s_axis_tdata[2:0]);
      sem_q  <= s_axis_tdata[7:3];
      pid_q  <= s_axis_tdata[29:8];
      prio_q <= s_axis_tdata[45:30] & PrioMask;
      part_q <= s_axis_tdata[53:46];
      rt_q   <= s_axis_tdata[54];
      glob_q <= s_axis_tdata[55];
    end
  end

  // table RAM: read at the incoming index while idle, hold it during execute
  assign sem_addr = SemW'(sem_q);
  assign raddr    = (state_q == S_IDLE) ? SemW'(s_axis_tdata[7:3]) : sem_addr;

  srpc_ram #(
    .Width (EntW),
    .Depth (NUM_SEMS)
  ) u_tab (
    .clk_i   (clk_i),
    .we_i    (fire && wr),
    .waddr_i (sem_addr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata_raw)
  );

  assign ent       = tvalid_q[sem_addr] ? tab_ent_t'(rdata_raw) : '0;
  assign valid_sem = ({1'b0, 4'b0, sem_q} < 10'(NUM_SEMS));

  // decision for the item in execute
  always_comb begin
    status  = ST_OK;
    exceeds = 1'b0;
    wr      = 1'b0;
    clr     = 1'b0;
    ins     = 1'b0;
    rem     = 1'b0;
    wdata   = ent;
    unique case (op_q) inside
      OP_ALLOC: begin
        if (!valid_sem) begin
          status = ST_PERM;
        end else begin
          clr = 1'b1;
          rem = ent.owner_valid;
        end
      end
      OP_OPEN: begin
        if (!valid_sem || !rt_q) begin
          status = ST_PERM;
        end else if (ent.owner_valid) begin
          status = ST_BUSY;
        end else if (ent.bound && (ent.part != part_q)) begin
          status = ST_PERM;
        end else begin
          wr          = 1'b1;
          wdata.bound = 1'b1;
          wdata.part  = part_q;
          if (beats(prio_q, pid_q, ent.ceil_prio, ent.ceil_pid)) begin
            wdata.ceil_prio = prio_q;
            wdata.ceil_pid  = pid_q;
          end
        end
      end
      OP_CLOSE, OP_UNLOCK: begin
        if (!valid_sem) begin
          status = ST_PERM;
        end else if (ent.owner_valid && (ent.owner_pid == pid_q)) begin
          wr                = 1'b1;
          rem               = 1'b1;
          wdata.owner_valid = 1'b0;
          wdata.owner_pid   = '0;
        end else if (op_q == OP_UNLOCK) begin
          status = ST_INVAL;
        end
      end
      OP_LOCK: begin
        // in list and owned always go together
        if (!valid_sem || !rt_q) begin
          status = ST_PERM;
        end else if (glob_q) begin
          status = ST_BUSY;
        end else if (ent.owner_valid) begin
          status = ST_INLIST;
        end else begin
          wr                = 1'b1;
          ins               = 1'b1;
          wdata.owner_valid = 1'b1;
          wdata.owner_pid   = pid_q;
        end
      end
      OP_CHECK: begin
        exceeds = !c_valid[0] ||
                  beats(prio_q, pid_q, c_key[0].prio, c_key[0].pid) ||
                  (c_key[0].owner == pid_q);
      end
      default: status = ST_PERM;
    endcase
  end

  // table valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tvalid_q <= '0;
    end else if (fire && clr) begin
      tvalid_q[sem_addr] <= 1'b0;
    end else if (fire && wr) begin
      tvalid_q[sem_addr] <= 1'b1;
    end
  end

  // command to the list
  assign cmd.ins       = fire && ins;
  assign cmd.rem       = fire && rem;
  assign cmd.key.prio  = ent.ceil_prio;
  assign cmd.key.pid   = ent.ceil_pid;
  assign cmd.key.owner = pid_q;

  // tail beyond the last cell reads as empty
  assign c_valid[NUM_SEMS] = 1'b0;
  assign c_key[NUM_SEMS]   = '0;
  assign c_sem[NUM_SEMS]   = '0;

  for (genvar i = 0; i < NUM_SEMS; i++) begin : g_cell
    logic            lb, lh, lv;
    key_t            lk;
    logic [SemW-1:0] ls;
    if (i == 0) begin : g_head
      assign lb = 1'b0;
      assign lh = 1'b0;
      assign lv = 1'b0;
      assign lk = '0;
      assign ls = '0;
    end else begin : g_body
      assign lb = c_beaten[i-1];
      assign lh = c_hit[i-1];
      assign lv = c_valid[i-1];
      assign lk = c_key[i-1];
      assign ls = c_sem[i-1];
    end
    srpc_cell #(
      .SemW (SemW)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .cmd_sem_i     (sem_addr),
      .left_beaten_i (lb),
      .left_hit_i    (lh),
      .left_valid_i  (lv),
      .left_key_i    (lk),
      .left_sem_i    (ls),
      .right_valid_i (c_valid[i+1]),
      .right_key_i   (c_key[i+1]),
      .right_sem_i   (c_sem[i+1]),
      .valid_o       (c_valid[i]),
      .key_o         (c_key[i]),
      .sem_o         (c_sem[i]),
      .beaten_o      (c_beaten[i]),
      .hit_o         (c_hit[i])
    );
  end

  // list head after this item
  always_comb begin
    if (cmd.ins && c_beaten[0]) begin
      head_v   = 1'b1;
      head_key = cmd.key;
    end else if (cmd.rem && c_hit[0]) begin
      head_v   = c_valid[1];
      head_key = c_key[1];
    end else begin
      head_v   = c_valid[0];
      head_key = c_key[0];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q  <= status;
      exceeds_q <= exceeds;
      topv_q    <= head_v;
      topp_q    <= head_v ? head_key.prio : '0;
      topid_q   <= head_v ? head_key.pid : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, topid_q, topp_q, topv_q, exceeds_q, status_q};

`ifndef SYNTH
  // occupied cells always form one run starting at the head
  a_list_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((c_valid[NUM_SEMS-1:0] & (c_valid[NUM_SEMS-1:0] + NUM_SEMS'(1))) == '0))
    else $error("ceiling list has a gap");

  // one list operation per item
  a_ins_rem_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.ins && cmd.rem))
    else $error("insert and remove issued together");

  // an insert leaves a nonempty list
  a_ins_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ins |=> c_valid[0])
    else $error("list head empty after insert");

  // a result is only produced by the execute step
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == S_EXEC))
    else $error("result appeared outside execute");

  // reported head matches the list head cell
  a_top_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(fire) |-> (topv_q == c_valid[0]))
    else $error("reported head disagrees with list");
`endif

endmodule

// ----- design/srpc_ram.sv -----
// ----------------------------------------------------------------------------
// srpc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srpc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- design/srpc_cell.sv -----
// ----------------------------------------------------------------------------
// srpc_cell
// One slot of the sorted ceiling list. Shifts right on insert, left on remove.
// ----------------------------------------------------------------------------
module srpc_cell #(
  parameter int unsigned SemW = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  srpc_pkg::chain_cmd_t cmd_i,
  input  logic [SemW-1:0]     cmd_sem_i,
  // left neighbor (toward the head)
  input  logic                left_beaten_i,
  input  logic                left_hit_i,
  input  logic                left_valid_i,
  input  srpc_pkg::key_t      left_key_i,
  input  logic [SemW-1:0]     left_sem_i,
  // right neighbor (toward the tail)
  input  logic                right_valid_i,
  input  srpc_pkg::key_t      right_key_i,
  input  logic [SemW-1:0]     right_sem_i,
  // own content and chain flags
  output logic                valid_o,
  output srpc_pkg::key_t      key_o,
  output logic [SemW-1:0]     sem_o,
  output logic                beaten_o,
  output logic                hit_o
);

  import srpc_pkg::*;

  logic            valid_q, valid_d;
  key_t            key_q, key_d;
  logic [SemW-1:0] sem_q, sem_d;

  // empty slots count as beaten so the new item lands on the first free one
  assign beaten_o = !valid_q || beats(cmd_i.key.prio, cmd_i.key.pid, key_q.prio, key_q.pid);
  // hit: the removed semaphore sits here or further toward the head
  assign hit_o    = (valid_q && (sem_q == cmd_sem_i)) || left_hit_i;

  // next content
  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    sem_d   = sem_q;
    if (cmd_i.ins && beaten_o) begin
      if (!left_beaten_i) begin
        valid_d = 1'b1;
        key_d   = cmd_i.key;
        sem_d   = cmd_sem_i;
      end else begin
        valid_d = left_valid_i;
        key_d   = left_key_i;
        sem_d   = left_sem_i;
      end
    end else if (cmd_i.rem && hit_o) begin
      valid_d = right_valid_i;
      key_d   = right_key_i;
      sem_d   = right_sem_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    sem_q <= sem_d;
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign sem_o   = sem_q;

endmodule

// ----- test/srp_ceiling_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srp_ceiling_unit_tb
// Self-checking bench for the SRP ceiling unit. A directed pass walks every
// operation and its error paths, then random traffic runs under three
// backpressure profiles. A scoreboard predicts each result from its own copy
// of the semaphore table and sorted ceiling list.
// ----------------------------------------------------------------------------
module srp_ceiling_unit_tb;
  import srpc_pkg::*;

  // Reserved operation codes
  localparam logic [OpW-1:0] OP_RSVD6 = 3'd6;
  localparam logic [OpW-1:0] OP_RSVD7 = 3'd7;
  localparam logic [PidW-1:0]  PID_MAX  = '1;
  localparam logic [PrioW-1:0] PRIO_MAX = '1;
  localparam int unsigned RAND_ITEMS = 530;

  typedef struct {
    logic [StatW-1:0] status;
    logic             exceeds;
    logic             top_valid;
    logic [PrioW-1:0] top_prio;
    logic [PidW-1:0]  top_pid;
  } ceiling_result_t;

  // Scoreboard: semaphore table model plus queue of predicted results
  class ceiling_scoreboard;
    logic [PrioW-1:0] ceil_prio[NumSems];
    logic [PidW-1:0]  ceil_pid[NumSems];
    bit               owner_valid[NumSems];
    logic [PidW-1:0]  owner_pid[NumSems];
    bit               bound[NumSems];
    logic [PartW-1:0] part[NumSems];
    bit               in_list[NumSems];
    int unsigned      order[NumSems];
    int unsigned      depth;
    ceiling_result_t  expected_q[$];
    int unsigned      errors, n_items, n_locks, n_unlocks, n_exceeds, max_depth;

    function new();
      for (int i = 0; i < NumSems; i++) begin
        ceil_prio[i] = '0; ceil_pid[i] = '0; owner_valid[i] = 1'b0; owner_pid[i] = '0;
        bound[i] = 1'b0; part[i] = '0; in_list[i] = 1'b0; order[i] = 0;
      end
      depth = 0; errors = 0; n_items = 0; n_locks = 0; n_unlocks = 0;
      n_exceeds = 0; max_depth = 0;
    endfunction

    // nonzero priority wins over zero, a larger one, or an equal one with higher pid
    function bit wins(logic [PrioW-1:0] ap, logic [PidW-1:0] apid,
                      logic [PrioW-1:0] bp, logic [PidW-1:0] bpid);
      if (ap == '0) return 1'b0;
      return (bp == '0) || (ap < bp) || ((ap == bp) && (apid < bpid));
    endfunction

    function void list_remove(int unsigned s);
      for (int unsigned i = 0; i < depth; i++) begin
        if (order[i] == s) begin
          for (int unsigned j = i; j + 1 < depth; j++) order[j] = order[j+1];
          depth--;
          break;
        end
      end
      in_list[s] = 1'b0;
    endfunction

    function void list_insert(int unsigned s);
      int unsigned pos;
      pos = depth;
      if (depth >= NumSems) return;
      for (int unsigned i = 0; i < depth; i++) begin
        if (wins(ceil_prio[s], ceil_pid[s], ceil_prio[order[i]], ceil_pid[order[i]])) begin
          pos = i;
          break;
        end
      end
      for (int unsigned i = depth; i > pos; i--) order[i] = order[i-1];
      order[pos] = s;
      depth++;
      in_list[s] = 1'b1;
    endfunction

    function void release_sem(int unsigned s);
      if (in_list[s]) list_remove(s);
      owner_valid[s] = 1'b0;
      owner_pid[s] = '0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Apply one accepted item and queue the result it must produce
    function void note_item(logic [55:0] d);
      logic [OpW-1:0]   op;
      int unsigned      s;
      logic [PidW-1:0]  pid;
      logic [PrioW-1:0] prio;
      logic [PartW-1:0] tpart;
      logic             rt, glob;
      ceiling_result_t  r;
      op = d[2:0]; s = 32'(d[7:3]); pid = d[29:8]; prio = d[45:30];
      tpart = d[53:46]; rt = d[54]; glob = d[55];
      r.status = ST_OK;
      r.exceeds = 1'b0;
      n_items++;
      if (op > OP_CHECK || (op != OP_CHECK && s >= NumSems)) begin
        r.status = ST_PERM;
      end else begin
        case (op)
          OP_ALLOC: begin
            if (in_list[s]) list_remove(s);
            ceil_prio[s] = '0; ceil_pid[s] = '0; owner_valid[s] = 1'b0;
            owner_pid[s] = '0; bound[s] = 1'b0; part[s] = '0;
          end
          OP_OPEN: begin
            if (!rt) r.status = ST_PERM;
            else if (owner_valid[s]) r.status = ST_BUSY;
            else begin
              if (!bound[s]) begin
                bound[s] = 1'b1;
                part[s] = tpart;
              end else if (part[s] != tpart) begin
                r.status = ST_PERM;
              end
              if (r.status == ST_OK && wins(prio, pid, ceil_prio[s], ceil_pid[s])) begin
                ceil_prio[s] = prio;
                ceil_pid[s] = pid;
              end
            end
          end
          OP_CLOSE: begin
            if (owner_valid[s] && owner_pid[s] == pid) release_sem(s);
          end
          OP_LOCK: begin
            if (!rt) r.status = ST_PERM;
            else if (glob) r.status = ST_BUSY;
            else if (in_list[s]) r.status = ST_INLIST;
            else if (owner_valid[s]) r.status = ST_BUSY;
            else begin
              list_insert(s);
              owner_valid[s] = 1'b1;
              owner_pid[s] = pid;
              n_locks++;
            end
          end
          OP_UNLOCK: begin
            if (!(owner_valid[s] && owner_pid[s] == pid)) r.status = ST_INVAL;
            else begin
              release_sem(s);
              n_unlocks++;
            end
          end
          default: begin
            if (depth == 0) r.exceeds = 1'b1;
            else r.exceeds = wins(prio, pid, ceil_prio[order[0]], ceil_pid[order[0]]) ||
                             (owner_valid[order[0]] && owner_pid[order[0]] == pid);
            if (r.exceeds) n_exceeds++;
          end
        endcase
      end
      if (depth > max_depth) max_depth = depth;
      r.top_valid = (depth != 0);
      r.top_prio  = (depth != 0) ? ceil_prio[order[0]] : '0;
      r.top_pid   = (depth != 0) ? ceil_pid[order[0]] : '0;
      expected_q.push_back(r);
    endfunction

    function void match_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compare one accepted result with the oldest prediction
    function void check_result(logic [47:0] d);
      ceiling_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: result %0h arrived with nothing expected", $time, d);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      match_field("status", 32'(e.status), 32'(d[2:0]));
      match_field("exceeds", 32'(e.exceeds), 32'(d[3]));
      match_field("top_valid", 32'(e.top_valid), 32'(d[4]));
      match_field("top_prio", 32'(e.top_prio), 32'(d[20:5]));
      match_field("top_pid", 32'(e.top_pid), 32'(d[42:21]));
      match_field("pad", 32'd0, 32'(d[47:43]));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  int unsigned tx_idle_pct = 29;
  int unsigned rx_idle_pct = 57;
  ceiling_scoreboard sb = new();

  srp_ceiling_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // 100 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [55:0] pack_item(logic [OpW-1:0] op, logic [4:0] s,
                                            logic [PidW-1:0] pid, logic [PrioW-1:0] prio,
                                            logic [PartW-1:0] tpart, logic rt, logic glob);
    return {glob, rt, tpart, prio, pid, s, op};
  endfunction

  // Present one item, with random idle cycles ahead of it
  task automatic send_item(input logic [55:0] d);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(d);
  endtask

  // Hold off the sender until every predicted result has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Mostly well-formed traffic over a small pid/priority pool, some full range
  task automatic random_item(output logic [55:0] d, output bit ignored);
    int unsigned      r;
    logic [OpW-1:0]   op;
    logic [4:0]       s;
    logic [PidW-1:0]  pid;
    logic [PrioW-1:0] prio;
    logic [PartW-1:0] tpart;
    logic             rt, glob;
    r = $urandom_range(0, 99);
    if (r < 8) op = OP_ALLOC;
    else if (r < 28) op = OP_OPEN;
    else if (r < 34) op = OP_CLOSE;
    else if (r < 58) op = OP_LOCK;
    else if (r < 80) op = OP_UNLOCK;
    else if (r < 97) op = OP_CHECK;
    else op = ($urandom_range(0, 1) != 0) ? OP_RSVD6 : OP_RSVD7;
    ignored = (op > OP_CHECK);

    s = ($urandom_range(0, 3) != 0) ? 5'($urandom_range(0, 11)) : 5'($urandom_range(0, 31));
    pid = ($urandom_range(0, 7) != 0) ? PidW'($urandom_range(0, 7)) : PidW'($urandom);
    r = $urandom_range(0, 9);
    if (r == 0) prio = '0;
    else if (r == 1) prio = PrioW'($urandom);
    else prio = PrioW'($urandom_range(1, 12));
    tpart = ($urandom_range(0, 9) == 0) ? PartW'($urandom) : PartW'($urandom_range(0, 3));
    rt = ($urandom_range(0, 15) != 0);
    glob = ($urandom_range(0, 15) == 0);

    // aim releases at semaphores that are actually held, and some checks at the head's owner
    if ((op == OP_UNLOCK || op == OP_CLOSE) && sb.depth != 0 && $urandom_range(0, 9) < 7)
      s = 5'(sb.order[$urandom_range(0, sb.depth - 1)]);
    if ((op == OP_UNLOCK || op == OP_CLOSE) && sb.owner_valid[s] && $urandom_range(0, 9) < 8)
      pid = sb.owner_pid[s];
    if (op == OP_CHECK && sb.depth != 0 && $urandom_range(0, 3) == 0)
      pid = sb.owner_pid[sb.order[0]];
    if (op == OP_OPEN && sb.bound[s] && $urandom_range(0, 9) < 8)
      tpart = sb.part[s];
    d = pack_item(op, s, pid, prio, tpart, rt, glob);
  endtask

  task automatic random_phase(input int unsigned n);
    logic [55:0] d;
    bit          ignored;
    int unsigned counted;
    counted = 0;
    while (counted < n) begin
      random_item(d, ignored);
      send_item(d);
      if (!ignored) counted++;
      if ($urandom_range(0, 199) == 0) drain_results();
    end
    drain_results();
  endtask

  // Receiver: check accepted results, stall at random
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Stimulus
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every op, error paths, list ordering and extremes
    send_item(pack_item(OP_CHECK,  5'd0,  '0,      '0,       8'd0,   1'b1, 1'b0));
    send_item(pack_item(OP_OPEN,   5'd0,  22'd3,   16'd5,    8'd0,   1'b0, 1'b0));
    send_item(pack_item(OP_OPEN,   5'd0,  22'd3,   16'd5,    8'd0,   1'b1, 1'b0));
    send_item(pack_item(OP_OPEN,   5'd0,  22'd3,   16'd4,    8'd255, 1'b1, 1'b0));
    send_item(pack_item(OP_OPEN,   5'd31, PID_MAX, PRIO_MAX, 8'd255, 1'b1, 1'b1));
    send_item(pack_item(OP_OPEN,   5'd1,  22'd1,   '0,       8'd7,   1'b1, 1'b0));
    send_item(pack_item(OP_OPEN,   5'd2,  22'd2,   16'd5,    8'd1,   1'b1, 1'b0));
    send_item(pack_item(OP_LOCK,   5'd1,  22'd1,   '0,       8'd0,   1'b1, 1'b0));
    send_item(pack_item(OP_LOCK,   5'd0,  22'd3,   '0,       8'd0,   1'b0, 1'b0));
    send_item(pack_item(OP_LOCK,   5'd0,  22'd3,   '0,       8'd0,   1'b1, 1'b1));
    send_item(pack_item(OP_LOCK,   5'd0,  22'd3,   '0,       8'd0,   1'b1, 1'b0));
    send_item(pack_item(OP_LOCK,   5'd0,  22'd5,   '0,       8'd0,   1'b1, 1'b0));
    send_item(pack_item(OP_LOCK,   5'd2,  22'd4,   '0,       8'd0,   1'b1, 1'b0));
    send_item(pack_item(OP_LOCK,   5'd31, PID_MAX, PRIO_MAX, 8'd255, 1'b1, 1'b0));
    send_item(pack_item(OP_OPEN,   5'd0,  22'd3,   16'd1,    8'd0,   1'b1, 1'b0));
    send_item(pack_item(OP_CHECK,  5'd9,  22'd1,   16'd5,    8'd0,   1'b1, 1'b0));
    send_item(pack_item(OP_CHECK,  5'd9,  22'd4,   PRIO_MAX, 8'd0,   1'b1, 1'b0));
    send_item(pack_item(OP_CHECK,  5'd9,  22'd9,   PRIO_MAX, 8'd0,   1'b1, 1'b0));
    send_item(pack_item(OP_CHECK,  5'd31, PID_MAX, '0,       8'd255, 1'b0, 1'b1));
    send_item(pack_item(OP_UNLOCK, 5'd2,  22'd9,   '0,       8'd0,   1'b1, 1'b0));
    send_item(pack_item(OP_UNLOCK, 5'd2,  22'd4,   '0,       8'd0,   1'b1, 1'b0));
    send_item(pack_item(OP_CLOSE,  5'd0,  22'd7,   '0,       8'd0,   1'b1, 1'b0));
    send_item(pack_item(OP_CLOSE,  5'd0,  22'd3,   '0,       8'd0,   1'b1, 1'b0));
    send_item(pack_item(OP_ALLOC,  5'd31, '0,      '0,       8'd0,   1'b1, 1'b0));
    send_item(pack_item(OP_RSVD6,  5'd1,  22'd1,   16'd1,    8'd0,   1'b1, 1'b0));
    send_item(pack_item(OP_RSVD7,  5'd1,  22'd1,   16'd1,    8'd0,   1'b1, 1'b0));
    drain_results();

    // random traffic under three backpressure profiles
    random_phase(RAND_ITEMS);
    tx_idle_pct = 57;
    rx_idle_pct = 29;
    random_phase(RAND_ITEMS);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_phase(RAND_ITEMS);

    repeat (10) @(posedge clk_i);
    $display("Ran %0d items: %0d locks and %0d unlocks granted, %0d checks above ceiling",
             sb.n_items, sb.n_locks, sb.n_unlocks, sb.n_exceeds);
    $display("Ceiling list reached %0d entries; %0d mismatches", sb.max_depth, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- srp_ceiling_unit.f -----
design/srpc_pkg.sv
design/srpc_ram.sv
design/srpc_cell.sv
design/srp_ceiling_unit.sv
test/srp_ceiling_unit_tb.sv
